>>> src/ardma_pkg.sv
// Shared types and constants for the aux RAM DMA register block.
`timescale 1ns / 1ps

package ardma_pkg;

   // Register selector codes carried by a request beat.
   localparam logic [3:0] SEL_MAIN_HI   = 4'd0;
   localparam logic [3:0] SEL_MAIN_LO   = 4'd1;
   localparam logic [3:0] SEL_AUX_HI    = 4'd2;
   localparam logic [3:0] SEL_AUX_LO    = 4'd3;
   localparam logic [3:0] SEL_COUNT_HI  = 4'd4;
   localparam logic [3:0] SEL_COUNT_LO  = 4'd5;
   localparam logic [3:0] SEL_MAIN_WORD = 4'd6;
   localparam logic [3:0] SEL_AUX_WORD  = 4'd7;
   localparam logic [3:0] SEL_COUNT_WRD = 4'd8;
   localparam logic [3:0] SEL_SIZE      = 4'd9;
   localparam logic [3:0] SEL_MODE      = 4'd10;
   localparam logic [3:0] SEL_REFRESH   = 4'd11;

   // Access kinds.
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_AUX_MEM_SIZE   = 2'd0;
   localparam logic [1:0] CSR_MAIN_ADDR_MASK = 2'd1;
   localparam logic [1:0] CSR_INT_MASK       = 2'd2;

   // Configuration reset values.
   localparam logic [31:0] AUX_MEM_SIZE_RST   = 32'h0100_0000;
   localparam logic [31:0] MAIN_ADDR_MASK_RST = 32'h01FF_FFFF;

   // Count bit that carries the transfer direction.
   localparam logic [31:0] COUNT_DIR_MASK = 32'h8000_0000;
   localparam logic [31:0] MODE_READ_VAL  = 32'h0000_0001;

   // Count half valid bits.
   localparam logic [1:0] HV_HIGH = 2'b01;
   localparam logic [1:0] HV_LOW  = 2'b10;
   localparam logic [1:0] HV_BOTH = 2'b11;

   // One request beat.
   typedef struct packed {
      logic        cmd;
      logic [3:0]  reg_sel;
      logic [31:0] wdata;
   } req_type;

   // One response beat.
   typedef struct packed {
      logic [31:0] rdata;
      logic        dma_start;
      logic        dma_dir;
      logic [31:0] dma_main_addr;
      logic [31:0] dma_aux_addr;
      logic [30:0] dma_length;
      logic        dma_zero_fill;
      logic        dma_done;
      logic        cpu_interrupt;
   } rsp_type;

   // Architectural register state.
   typedef struct packed {
      logic [31:0] main_addr;
      logic [31:0] aux_addr;
      logic [31:0] count;
      logic [1:0]  half_valid;
      logic [15:0] size;
   } regs_type;

   // Configuration register values.
   typedef struct packed {
      logic [31:0] aux_mem_size;
      logic [31:0] main_addr_mask;
      logic        int_mask;
   } cfg_type;

endpackage

>>> src/ardma_exec.sv
// Execute logic: decodes one access, updates registers and forms the DMA command.
`timescale 1ns / 1ps

module ardma_exec
   import ardma_pkg::*;
(
   input  req_type  req,
   input  regs_type regs,
   input  cfg_type  cfg,
   output regs_type regs_next,
   output rsp_type  rsp
);

   logic [31:0] wr_hi_main;
   logic [31:0] wr_lo_main;
   logic [31:0] wr_hi_aux;
   logic [31:0] wr_lo_aux;
   logic [31:0] count_new;
   logic [1:0]  hv_new;
   logic        count_wr;
   logic        fire;
   logic        dir;
   logic        out_of_range;
   logic        issue;

   // Half-word merges for the address registers.
   assign wr_hi_main = {req.wdata[15:0], regs.main_addr[15:0]};
   assign wr_lo_main = {regs.main_addr[31:16], req.wdata[15:0]};
   assign wr_hi_aux  = {req.wdata[15:0], regs.aux_addr[15:0]};
   assign wr_lo_aux  = {regs.aux_addr[31:16], req.wdata[15:0]};

   // Count write decode: new count value and half valid bits.
   always_comb begin
      count_wr  = 1'b0;
      count_new = regs.count;
      hv_new    = regs.half_valid;
      if (req.cmd == CMD_WRITE) begin
         case (req.reg_sel)
            SEL_COUNT_HI: begin
               count_wr  = 1'b1;
               count_new = {req.wdata[15:0], regs.count[15:0]};
               hv_new    = regs.half_valid | HV_HIGH;
            end
            SEL_COUNT_LO: begin
               count_wr  = 1'b1;
               count_new = {regs.count[31:16], req.wdata[15:0]};
               hv_new    = regs.half_valid | HV_LOW;
            end
            SEL_COUNT_WRD: begin
               count_wr  = 1'b1;
               count_new = req.wdata;
               hv_new    = HV_BOTH;
            end
            default: begin
               count_wr = 1'b0;
            end
         endcase
      end
   end

   // Transfer decision once both count halves are in.
   assign fire         = count_wr && (hv_new == HV_BOTH);
   assign dir          = count_new[31];
   assign out_of_range = (regs.aux_addr >= cfg.aux_mem_size);
   assign issue        = fire && (dir || !out_of_range);

   // Next register state.
   always_comb begin
      regs_next = regs;
      if (req.cmd == CMD_WRITE) begin
         case (req.reg_sel)
            SEL_MAIN_HI:   regs_next.main_addr = wr_hi_main;
            SEL_MAIN_LO:   regs_next.main_addr = wr_lo_main;
            SEL_AUX_HI:    regs_next.aux_addr  = wr_hi_aux;
            SEL_AUX_LO:    regs_next.aux_addr  = wr_lo_aux;
            SEL_MAIN_WORD: regs_next.main_addr = req.wdata;
            SEL_AUX_WORD:  regs_next.aux_addr  = req.wdata;
            SEL_SIZE:      regs_next.size      = req.wdata[15:0];
            default: begin
               regs_next.main_addr = regs.main_addr;
            end
         endcase
      end
      if (count_wr) begin
         // A completed transfer leaves only the direction bit of the count.
         regs_next.count      = issue ? (count_new & COUNT_DIR_MASK) : count_new;
         regs_next.half_valid = fire ? 2'b00 : hv_new;
      end
   end

   // Response beat: read data on reads, DMA command on an issuing write.
   always_comb begin
      rsp = '0;
      if (req.cmd == CMD_READ) begin
         case (req.reg_sel)
            SEL_MAIN_HI:   rsp.rdata = {16'h0000, regs.main_addr[31:16]};
            SEL_MAIN_LO:   rsp.rdata = {16'h0000, regs.main_addr[15:0]};
            SEL_AUX_HI:    rsp.rdata = {16'h0000, regs.aux_addr[31:16]};
            SEL_AUX_LO:    rsp.rdata = {16'h0000, regs.aux_addr[15:0]};
            SEL_COUNT_HI:  rsp.rdata = {16'h0000, regs.count[31:16]};
            SEL_COUNT_LO:  rsp.rdata = {16'h0000, regs.count[15:0]};
            SEL_MAIN_WORD: rsp.rdata = regs.main_addr;
            SEL_AUX_WORD:  rsp.rdata = regs.aux_addr;
            SEL_COUNT_WRD: rsp.rdata = regs.count;
            SEL_SIZE:      rsp.rdata = {16'h0000, regs.size};
            SEL_MODE:      rsp.rdata = MODE_READ_VAL;
            default:       rsp.rdata = 32'h0000_0000;
         endcase
      end
      if (issue) begin
         rsp.dma_start     = 1'b1;
         rsp.dma_dir       = dir;
         rsp.dma_main_addr = regs.main_addr & cfg.main_addr_mask;
         rsp.dma_aux_addr  = regs.aux_addr;
         rsp.dma_length    = count_new[30:0];
         rsp.dma_zero_fill = out_of_range;
         rsp.dma_done      = 1'b1;
         rsp.cpu_interrupt = cfg.int_mask;
      end
   end

endmodule

>>> src/aux_ram_dma_register_block_unit.sv
// Top level of the aux RAM DMA register block: beat registers, state and CSRs.
`timescale 1ns / 1ps

// Register front end of an auxiliary-RAM DMA interface.
// Request channel (req_*): one beat is one register access, cmd 0 read or
// 1 write, with a register selector and 32-bit write data. A beat is taken
// on a rising edge with req_valid high and req_stall low.
// Response channel (rsp_*): one beat per request, in order, carrying read
// data and the DMA command fields (all zero unless a transfer was issued).
// A beat is delivered on a rising edge with rsp_valid high and rsp_stall low.
// CSR channel (csr_*): writes aux_mem_size, main_addr_mask and int_mask by
// index; csr_ready is always high. Write CSRs only while the block is idle.
// An accepted beat executes in a single pass out of the input register
// and loads the response register once that register is free.
// Throughput: one beat per cycle while the receiver does not stall,
// limited only by the response register.
// When the receiver stalls, the response holds and the input register keeps
// its beat; req_stall rises only while both registers are full and blocked.
// Reset clears all registers, the count half valids and both beat stages,
// and loads the CSR reset values.

module aux_ram_dma_register_block_unit
   import ardma_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [3:0]  req_reg_sel,
   input  logic [31:0] req_wdata,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_rdata,
   output logic        rsp_dma_start,
   output logic        rsp_dma_dir,
   output logic [31:0] rsp_dma_main_addr,
   output logic [31:0] rsp_dma_aux_addr,
   output logic [30:0] rsp_dma_length,
   output logic        rsp_dma_zero_fill,
   output logic        rsp_dma_done,
   output logic        rsp_cpu_interrupt,
   // CSR write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic     in_valid_ff;
   req_type  in_req_ff;
   logic     out_valid_ff;
   rsp_type  out_rsp_ff;
   regs_type regs_ff;
   regs_type regs_in;
   cfg_type  cfg_ff;
   rsp_type  exec_rsp;
   logic     advance;
   logic     req_take;
   logic     csr_take;

   // Handshake: the input stage moves on whenever the response register frees.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   // Input beat register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance || !in_valid_ff) begin
         in_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff <= '{cmd: req_cmd, reg_sel: req_reg_sel, wdata: req_wdata};
      end
   end

   // Single-pass execute of the held beat.
   ardma_exec u_exec (
      .req       (in_req_ff),
      .regs      (regs_ff),
      .cfg       (cfg_ff),
      .regs_next (regs_in),
      .rsp       (exec_rsp)
   );

   // Register state commits when the beat moves to the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else if (in_valid_ff && advance) begin
         regs_ff <= regs_in;
      end
   end

   // Response beat register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff && advance) begin
         out_rsp_ff <= exec_rsp;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.aux_mem_size   <= AUX_MEM_SIZE_RST;
         cfg_ff.main_addr_mask <= MAIN_ADDR_MASK_RST;
         cfg_ff.int_mask       <= 1'b0;
      end else if (csr_take) begin
         case (csr_index)
            CSR_AUX_MEM_SIZE:   cfg_ff.aux_mem_size   <= csr_wdata;
            CSR_MAIN_ADDR_MASK: cfg_ff.main_addr_mask <= csr_wdata;
            CSR_INT_MASK:       cfg_ff.int_mask       <= csr_wdata[0];
            default: begin
               cfg_ff.int_mask <= cfg_ff.int_mask;
            end
         endcase
      end
   end

   // Response ports.
   assign rsp_valid         = out_valid_ff;
   assign rsp_rdata         = out_rsp_ff.rdata;
   assign rsp_dma_start     = out_rsp_ff.dma_start;
   assign rsp_dma_dir       = out_rsp_ff.dma_dir;
   assign rsp_dma_main_addr = out_rsp_ff.dma_main_addr;
   assign rsp_dma_aux_addr  = out_rsp_ff.dma_aux_addr;
   assign rsp_dma_length    = out_rsp_ff.dma_length;
   assign rsp_dma_zero_fill = out_rsp_ff.dma_zero_fill;
   assign rsp_dma_done      = out_rsp_ff.dma_done;
   assign rsp_cpu_interrupt = out_rsp_ff.cpu_interrupt;

   // An issued transfer always completes and reports done.
   a_start_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dma_start) |-> rsp_dma_done)
      else $error("dma_start without dma_done");

   // The interrupt line only pulses with a completion.
   a_irq_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cpu_interrupt) |-> rsp_dma_done)
      else $error("cpu_interrupt without dma_done");

   // Issuing a transfer clears both count half valids.
   a_hv_clear: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance && exec_rsp.dma_start) |=> (regs_ff.half_valid == 2'b00))
      else $error("count half valids not cleared after issue");

   // A transfer keeps only the direction bit of the count.
   a_count_clr: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance && exec_rsp.dma_start) |=> (regs_ff.count[30:0] == 31'd0))
      else $error("count not cleared after issue");

endmodule

>>> tb/sv/aux_ram_dma_register_block_unit_test.sv
// Self-checking testbench for the aux RAM DMA register block top level.
`timescale 1ns / 1ps

module aux_ram_dma_register_block_unit_test
   import ardma_pkg::*;
();

   localparam int CLOCK_HALF = 6;
   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEMS_PER_PHASE = 300;
   localparam int PHASE_COUNT = 6;
   localparam int TAIL_CYCLES = 4;
   localparam logic [3:0] SEL_UNUSED_LO = 4'd12;
   localparam logic [3:0] SEL_UNUSED_HI = 4'd15;

   // Register model of the block and the queue of responses it owes.
   class dma_reg_scoreboard;
      regs_type regs;
      cfg_type cfg;
      rsp_type owed_responses[$];
      int errors;

      function new();
         regs = '0;
         cfg.aux_mem_size = AUX_MEM_SIZE_RST;
         cfg.main_addr_mask = MAIN_ADDR_MASK_RST;
         cfg.int_mask = 1'b0;
         errors = 0;
      endfunction

      function void note_config(logic [1:0] index, logic [31:0] value);
         case (index)
            CSR_AUX_MEM_SIZE: cfg.aux_mem_size = value;
            CSR_MAIN_ADDR_MASK: cfg.main_addr_mask = value;
            CSR_INT_MASK: cfg.int_mask = value[0];
            default: ;
         endcase
      endfunction

      // Applies one register access and returns the response it produces.
      function rsp_type access_outcome(req_type beat);
         rsp_type outcome;
         logic dir;
         logic zero_fill;
         outcome = '0;
         if (beat.cmd == CMD_READ) begin
            case (beat.reg_sel)
               SEL_MAIN_HI: outcome.rdata = {16'h0, regs.main_addr[31:16]};
               SEL_MAIN_LO: outcome.rdata = {16'h0, regs.main_addr[15:0]};
               SEL_AUX_HI: outcome.rdata = {16'h0, regs.aux_addr[31:16]};
               SEL_AUX_LO: outcome.rdata = {16'h0, regs.aux_addr[15:0]};
               SEL_COUNT_HI: outcome.rdata = {16'h0, regs.count[31:16]};
               SEL_COUNT_LO: outcome.rdata = {16'h0, regs.count[15:0]};
               SEL_MAIN_WORD: outcome.rdata = regs.main_addr;
               SEL_AUX_WORD: outcome.rdata = regs.aux_addr;
               SEL_COUNT_WRD: outcome.rdata = regs.count;
               SEL_SIZE: outcome.rdata = {16'h0, regs.size};
               SEL_MODE: outcome.rdata = MODE_READ_VAL;
               default: outcome.rdata = '0;
            endcase
            return outcome;
         end
         case (beat.reg_sel)
            SEL_MAIN_HI: regs.main_addr[31:16] = beat.wdata[15:0];
            SEL_MAIN_LO: regs.main_addr[15:0] = beat.wdata[15:0];
            SEL_AUX_HI: regs.aux_addr[31:16] = beat.wdata[15:0];
            SEL_AUX_LO: regs.aux_addr[15:0] = beat.wdata[15:0];
            SEL_COUNT_HI: begin
               regs.count[31:16] = beat.wdata[15:0];
               regs.half_valid = regs.half_valid | HV_HIGH;
            end
            SEL_COUNT_LO: begin
               regs.count[15:0] = beat.wdata[15:0];
               regs.half_valid = regs.half_valid | HV_LOW;
            end
            SEL_MAIN_WORD: regs.main_addr = beat.wdata;
            SEL_AUX_WORD: regs.aux_addr = beat.wdata;
            SEL_COUNT_WRD: begin
               regs.count = beat.wdata;
               regs.half_valid = HV_BOTH;
            end
            SEL_SIZE: regs.size = beat.wdata[15:0];
            default: ;
         endcase
         // Both count halves present: issue the transfer, which completes at once.
         if (regs.half_valid == HV_BOTH) begin
            regs.half_valid = '0;
            dir = regs.count[31];
            zero_fill = 1'b0;
            if (regs.aux_addr >= cfg.aux_mem_size) begin
               // An out-of-range write toward aux memory is dropped silently.
               if (!dir) return outcome;
               zero_fill = 1'b1;
            end
            outcome.dma_start = 1'b1;
            outcome.dma_dir = dir;
            outcome.dma_main_addr = regs.main_addr & cfg.main_addr_mask;
            outcome.dma_aux_addr = regs.aux_addr;
            outcome.dma_length = regs.count[30:0];
            outcome.dma_zero_fill = zero_fill;
            outcome.dma_done = 1'b1;
            outcome.cpu_interrupt = cfg.int_mask;
            regs.count = regs.count & COUNT_DIR_MASK;
         end
         return outcome;
      endfunction

      function void note_request(req_type beat);
         owed_responses.push_back(access_outcome(beat));
      endfunction

      function int pending();
         return owed_responses.size();
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (owed_responses.size() == 0) begin
            $error("response beat arrived with none outstanding");
            errors++;
            return;
         end
         want = owed_responses.pop_front();
         check_field("rdata", want.rdata, got.rdata);
         check_field("dma_start", want.dma_start, got.dma_start);
         check_field("dma_dir", want.dma_dir, got.dma_dir);
         check_field("dma_main_addr", want.dma_main_addr, got.dma_main_addr);
         check_field("dma_aux_addr", want.dma_aux_addr, got.dma_aux_addr);
         check_field("dma_length", want.dma_length, got.dma_length);
         check_field("dma_zero_fill", want.dma_zero_fill, got.dma_zero_fill);
         check_field("dma_done", want.dma_done, got.dma_done);
         check_field("cpu_interrupt", want.cpu_interrupt, got.cpu_interrupt);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_cmd;
   logic [3:0]  req_reg_sel;
   logic [31:0] req_wdata;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_rdata;
   logic        rsp_dma_start;
   logic        rsp_dma_dir;
   logic [31:0] rsp_dma_main_addr;
   logic [31:0] rsp_dma_aux_addr;
   logic [30:0] rsp_dma_length;
   logic        rsp_dma_zero_fill;
   logic        rsp_dma_done;
   logic        rsp_cpu_interrupt;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   dma_reg_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int items_sent;
   int cycle_count;

   aux_ram_dma_register_block_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_reg_sel(req_reg_sel),
      .req_wdata(req_wdata),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_rdata(rsp_rdata),
      .rsp_dma_start(rsp_dma_start),
      .rsp_dma_dir(rsp_dma_dir),
      .rsp_dma_main_addr(rsp_dma_main_addr),
      .rsp_dma_aux_addr(rsp_dma_aux_addr),
      .rsp_dma_length(rsp_dma_length),
      .rsp_dma_zero_fill(rsp_dma_zero_fill),
      .rsp_dma_done(rsp_dma_done),
      .rsp_cpu_interrupt(rsp_cpu_interrupt),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // Watchdog on the total run length.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("aux_ram_dma_register_block_unit_test: FAIL");
         $finish;
      end
   end

   // Receiver back-pressure, updated on each falling edge.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Every accepted response beat is checked against the oldest owed one.
   always @(posedge clock) begin : rsp_monitor
      rsp_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.rdata = rsp_rdata;
         got.dma_start = rsp_dma_start;
         got.dma_dir = rsp_dma_dir;
         got.dma_main_addr = rsp_dma_main_addr;
         got.dma_aux_addr = rsp_dma_aux_addr;
         got.dma_length = rsp_dma_length;
         got.dma_zero_fill = rsp_dma_zero_fill;
         got.dma_done = rsp_dma_done;
         got.cpu_interrupt = rsp_cpu_interrupt;
         sb.check_response(got);
      end
   end

   // Sends one request beat; called and returning at a falling edge.
   task automatic send_access(input logic cmd, input logic [3:0] sel, input logic [31:0] data);
      req_type beat;
      beat.cmd = cmd;
      beat.reg_sel = sel;
      beat.wdata = data;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd = beat.cmd;
      req_reg_sel = beat.reg_sel;
      req_wdata = beat.wdata;
      do @(posedge clock); while (req_stall);
      sb.note_request(beat);
      items_sent++;
      @(negedge clock);
   endtask

   // Writes a 32-bit value either as one word or as two halves in random order.
   task automatic write_reg_pair(input logic [3:0] sel_hi, sel_lo, sel_word,
                                 input logic [31:0] value);
      logic [15:0] junk;
      junk = 16'($urandom());
      case ($urandom_range(0, 2))
         0: send_access(CMD_WRITE, sel_word, value);
         1: begin
            send_access(CMD_WRITE, sel_hi, {junk, value[31:16]});
            send_access(CMD_WRITE, sel_lo, {~junk, value[15:0]});
         end
         default: begin
            send_access(CMD_WRITE, sel_lo, {junk, value[15:0]});
            send_access(CMD_WRITE, sel_hi, {~junk, value[31:16]});
         end
      endcase
   endtask

   // Lowers valid and waits until every owed response has been delivered.
   task automatic drain();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      sb.note_config(index, value);
      @(negedge clock);
      csr_valid = 1'b0;
      @(negedge clock);
   endtask

   // One programmed transfer with random content, then perhaps a read-back.
   task automatic run_transfer_sequence();
      logic [31:0] aux_addr;
      logic [31:0] count;
      if ($urandom_range(0, 3) != 0)
         write_reg_pair(SEL_MAIN_HI, SEL_MAIN_LO, SEL_MAIN_WORD, $urandom());
      // Aux addresses cluster around the range boundary.
      case ($urandom_range(0, 4))
         0: aux_addr = $urandom();
         1: aux_addr = sb.cfg.aux_mem_size;
         2: aux_addr = sb.cfg.aux_mem_size - 1;
         3: aux_addr = sb.cfg.aux_mem_size + 1;
         default: aux_addr = $urandom_range(0, 32'h0000_FFFF);
      endcase
      if ($urandom_range(0, 4) != 0)
         write_reg_pair(SEL_AUX_HI, SEL_AUX_LO, SEL_AUX_WORD, aux_addr);
      if ($urandom_range(0, 1) == 0)
         count = $urandom();
      else
         count = {1'($urandom_range(0, 1)), 31'($urandom_range(0, 4096))};
      write_reg_pair(SEL_COUNT_HI, SEL_COUNT_LO, SEL_COUNT_WRD, count);
      if ($urandom_range(0, 1) == 0)
         send_access(CMD_READ, 4'($urandom_range(0, 15)), $urandom());
   endtask

   // Main stimulus: reset, directed accesses, then random phases.
   initial begin
      int phase;
      int phase_start;
      logic [31:0] size_val;
      logic [31:0] mask_val;
      logic [31:0] int_val;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_READ;
      req_reg_sel = SEL_MAIN_HI;
      req_wdata = '0;
      csr_valid = 1'b0;
      csr_index = CSR_AUX_MEM_SIZE;
      csr_wdata = '0;
      send_idle_pct = 32;
      recv_idle_pct = 67;
      items_sent = 0;
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset values, mode and refresh reads, and an unused selector.
      send_access(CMD_READ, SEL_MODE, 32'hFFFF_FFFF);
      send_access(CMD_READ, SEL_REFRESH, '0);
      send_access(CMD_READ, SEL_UNUSED_HI, '0);
      send_access(CMD_READ, SEL_COUNT_WRD, '0);
      // Half writes keep the other half and ignore the upper write data.
      send_access(CMD_WRITE, SEL_MAIN_WORD, 32'hFFFF_FFFF);
      send_access(CMD_WRITE, SEL_MAIN_LO, 32'hABCD_0000);
      send_access(CMD_READ, SEL_MAIN_WORD, '0);
      send_access(CMD_WRITE, SEL_MAIN_HI, 32'h5555_1234);
      send_access(CMD_READ, SEL_MAIN_HI, '0);
      // In-range transfer toward aux memory with the longest length.
      send_access(CMD_WRITE, SEL_AUX_WORD, '0);
      send_access(CMD_WRITE, SEL_COUNT_WRD, 32'h7FFF_FFFF);
      send_access(CMD_READ, SEL_COUNT_WRD, '0);
      // Transfer launched by two count halves, toward main memory.
      send_access(CMD_WRITE, SEL_COUNT_HI, 32'hFFFF_8000);
      send_access(CMD_WRITE, SEL_COUNT_LO, 32'h0000_FFFF);
      // An out-of-range write is dropped and keeps the count.
      send_access(CMD_WRITE, SEL_AUX_WORD, 32'hFFFF_FFFF);
      send_access(CMD_WRITE, SEL_COUNT_WRD, 32'h0000_0010);
      send_access(CMD_READ, SEL_COUNT_WRD, '0);
      // An out-of-range read becomes a zero-fill.
      send_access(CMD_WRITE, SEL_COUNT_WRD, 32'h8000_0020);
      send_access(CMD_READ, SEL_COUNT_WRD, '0);
      // Size register and writes that have no effect.
      send_access(CMD_WRITE, SEL_SIZE, 32'hFFFF_FFFF);
      send_access(CMD_READ, SEL_SIZE, '0);
      send_access(CMD_WRITE, SEL_MODE, 32'hFFFF_FFFF);
      send_access(CMD_WRITE, SEL_REFRESH, 32'hFFFF_FFFF);
      send_access(CMD_WRITE, SEL_UNUSED_LO, 32'hFFFF_FFFF);
      send_access(CMD_READ, SEL_AUX_HI, '0);

      // Random phases; each later phase drains and writes a new configuration, and phases share idling mixes in pairs.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase != 0) begin
            drain();
            case (phase)
               1: begin size_val = '0; mask_val = 32'hFFFF_FFFF; int_val = 1; end
               2: begin size_val = 32'hFFFF_FFFF; mask_val = '0; int_val = 0; end
               3: begin size_val = 32'h0000_8000; mask_val = $urandom(); int_val = 1; end
               4: begin
                  size_val = AUX_MEM_SIZE_RST;
                  mask_val = MAIN_ADDR_MASK_RST;
                  int_val = 1;
               end
               default: begin
                  size_val = $urandom_range(0, 32'h0002_0000);
                  mask_val = $urandom();
                  int_val = $urandom_range(0, 1);
               end
            endcase
            write_csr(CSR_AUX_MEM_SIZE, size_val);
            write_csr(CSR_MAIN_ADDR_MASK, mask_val);
            write_csr(CSR_INT_MASK, int_val);
         end
         if (phase < 2) begin
            send_idle_pct = 32;
            recv_idle_pct = 67;
         end else if (phase < 4) begin
            send_idle_pct = 67;
            recv_idle_pct = 32;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         phase_start = items_sent;
         while (items_sent - phase_start < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) < 7)
               run_transfer_sequence();
            else
               send_access(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), $urandom());
         end
      end

      drain();
      if (sb.errors == 0)
         $display("aux_ram_dma_register_block_unit_test: PASS");
      else
         $display("aux_ram_dma_register_block_unit_test: FAIL");
      $finish;
   end

endmodule

>>> files.f
src/ardma_pkg.sv
src/ardma_exec.sv
src/aux_ram_dma_register_block_unit.sv
tb/sv/aux_ram_dma_register_block_unit_test.sv
